>>> hdl/http_chunked_body_decoder_core_defines.svh
// Assertion macros shared by the chunked body decoder modules.
// Each check is sampled on the rising clock edge and is off while reset is held.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH
`define HCBD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("hcbd same-cycle check failed");
`define HCBD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("hcbd next-cycle check failed");
`else
`define HCBD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define HCBD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

>>> hdl/hcbd_pkg.sv
package hcbd_pkg;

    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_END  = 2'd1,
        K_ERR  = 2'd2
    } kind_t;

    // One queue entry holds every result caused by one input byte.
    // The second result, when present, is always an end or error marker.
    typedef struct packed {
        logic        two;
        kind_t       kind_b;
        kind_t       kind_a;
        logic [7:0]  data;
    } hcbd_entry_t;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

endpackage

>>> hdl/hcbd_front.sv
`include "http_chunked_body_decoder_core_defines.svh"

module hcbd_front
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    output logic        q_push,
    output hcbd_entry_t q_entry,
    input  logic        q_full
);

    typedef enum logic [4:0] {
        PH_SIZE  = 5'b00001,
        PH_DATA  = 5'b00010,
        PH_TRAIL = 5'b00100,
        PH_DONE  = 5'b01000,
        PH_ERR   = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   size_accum_reg, size_accum_next;
    logic [SIZE_BITS-1:0]   bytes_left_reg, bytes_left_next;
    logic                   closed_reg, closed_next;
    logic                   saw_reg, saw_next;

    logic                   accept;
    logic                   is_hex;
    logic [3:0]             hval;
    logic                   is_lf;
    logic                   is_cr;
    logic                   is_blank;
    logic                   acc_ovf;
    logic [SIZE_BITS-1:0]   acc_shift;
    logic [SIZE_BITS-1:0]   bl_dec;
    logic                   push_v;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept && push_v;

    assign is_lf    = (s_tdata == CH_LF);
    assign is_cr    = (s_tdata == CH_CR);
    assign is_blank = (s_tdata inside {CH_SPACE, CH_TAB});

    // Letters a-f and A-F share their low nibble pattern: 1..6 maps to 10..15.
    always_comb
    begin
        is_hex = 1'b0;
        hval   = 4'd0;
        if (s_tdata inside {[8'h30:8'h39]})
        begin
            is_hex = 1'b1;
            hval   = s_tdata[3:0];
        end
        else if (s_tdata inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            is_hex = 1'b1;
            hval   = s_tdata[3:0] + 4'd9;
        end
    end

    assign acc_ovf   = (size_accum_reg[SIZE_BITS-1 -: 4] != 4'd0);
    assign acc_shift = {size_accum_reg[SIZE_BITS-5:0], hval};
    assign bl_dec    = bytes_left_reg - SIZE_BITS'(1);

    always_comb
    begin
        logic [SIZE_BITS-1:0] acc_v;
        logic                 ovf_v;

        acc_v           = size_accum_reg;
        ovf_v           = 1'b0;
        phase_next      = phase_reg;
        size_accum_next = size_accum_reg;
        bytes_left_next = bytes_left_reg;
        closed_next     = closed_reg;
        saw_next        = saw_reg;
        push_v          = 1'b0;
        q_entry.data    = 8'd0;
        q_entry.kind_a  = K_DATA;
        q_entry.kind_b  = K_END;
        q_entry.two     = 1'b0;

        case (phase_reg)
            PH_SIZE:
            begin
                if (is_lf || s_tlast)
                begin
                    // The line ends here; the final byte may still carry a digit.
                    if (!is_lf && !is_cr && !closed_reg && is_hex)
                    begin
                        if (acc_ovf)
                            ovf_v = 1'b1;
                        else
                            acc_v = acc_shift;
                    end
                    size_accum_next = acc_v;
                    if (ovf_v)
                    begin
                        push_v         = 1'b1;
                        q_entry.kind_a = K_ERR;
                        phase_next     = PH_ERR;
                    end
                    else if (acc_v == '0)
                    begin
                        push_v         = 1'b1;
                        q_entry.kind_a = K_END;
                        phase_next     = PH_DONE;
                    end
                    else if (s_tlast)
                    begin
                        push_v         = 1'b1;
                        q_entry.kind_a = K_ERR;
                        phase_next     = PH_ERR;
                    end
                    else
                    begin
                        bytes_left_next = acc_v;
                        phase_next      = PH_DATA;
                    end
                end
                else if (!is_cr && !closed_reg)
                begin
                    if (is_hex)
                    begin
                        if (acc_ovf)
                        begin
                            push_v         = 1'b1;
                            q_entry.kind_a = K_ERR;
                            phase_next     = PH_ERR;
                        end
                        else
                        begin
                            size_accum_next = acc_shift;
                            saw_next        = 1'b1;
                        end
                    end
                    else if (!(is_blank && !saw_reg))
                    begin
                        closed_next = 1'b1;
                    end
                end
            end
            PH_DATA:
            begin
                push_v          = 1'b1;
                q_entry.kind_a  = K_DATA;
                q_entry.data    = s_tdata;
                bytes_left_next = bl_dec;
                if (bl_dec == '0)
                begin
                    phase_next = PH_TRAIL;
                    if (s_tlast)
                    begin
                        q_entry.two    = 1'b1;
                        q_entry.kind_b = K_END;
                    end
                end
                else if (s_tlast)
                begin
                    q_entry.two    = 1'b1;
                    q_entry.kind_b = K_ERR;
                end
            end
            PH_TRAIL:
            begin
                if (s_tlast)
                begin
                    push_v         = 1'b1;
                    q_entry.kind_a = K_END;
                end
                else if (is_lf)
                begin
                    size_accum_next = '0;
                    closed_next     = 1'b0;
                    saw_next        = 1'b0;
                    phase_next      = PH_SIZE;
                end
            end
            default:
            begin
            end
        endcase

        // The last byte of a message leaves the decoder ready for the next one.
        if (s_tlast)
        begin
            phase_next      = PH_SIZE;
            size_accum_next = '0;
            bytes_left_next = '0;
            closed_next     = 1'b0;
            saw_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            size_accum_reg <= '0;
            bytes_left_reg <= '0;
            closed_reg     <= 1'b0;
            saw_reg        <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            size_accum_reg <= size_accum_next;
            bytes_left_reg <= bytes_left_next;
            closed_reg     <= closed_next;
            saw_reg        <= saw_next;
        end
    end

    `HCBD_ASSERT_IMP(a_data_count_live, clk, rst_n, phase_reg == PH_DATA, bytes_left_reg != '0)

endmodule

>>> hdl/hcbd_queue.sv
`include "http_chunked_body_decoder_core_defines.svh"

module hcbd_queue
    import hcbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  hcbd_entry_t wr_entry,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output hcbd_entry_t rd_entry
);

    hcbd_entry_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]      wr_ptr_reg;
    logic [Q_AW-1:0]      rd_ptr_reg;
    logic [Q_CW-1:0]      count_reg;
    logic [Q_CW-1:0]      count_next;

    assign full     = (count_reg == Q_CW'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + Q_CW'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            count_reg <= count_next;
        end
    end

    `HCBD_ASSERT_IMP(a_no_overrun, clk, rst_n, push, !full || pop)
    `HCBD_ASSERT_IMP(a_no_underrun, clk, rst_n, pop, !empty)

endmodule

>>> hdl/hcbd_back.sv
`include "http_chunked_body_decoder_core_defines.svh"

module hcbd_back
    import hcbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  hcbd_entry_t q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    kind_t       m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;
    logic        pend_reg, pend_next;
    kind_t       kind_b_reg, kind_b_next;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // A pending second result goes out before the next queue entry is taken.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        pend_next     = pend_reg;
        kind_b_next   = kind_b_reg;
        q_pop         = 1'b0;
        if (out_free)
        begin
            if (pend_reg)
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = 8'd0;
                m_tuser_next  = kind_b_reg;
                m_tlast_next  = 1'b1;
                pend_next     = 1'b0;
            end
            else if (!q_empty)
            begin
                q_pop         = 1'b1;
                m_tvalid_next = 1'b1;
                m_tdata_next  = q_head.data;
                m_tuser_next  = q_head.kind_a;
                m_tlast_next  = !q_head.two;
                pend_next     = q_head.two;
                kind_b_next   = q_head.kind_b;
            end
            else
            begin
                m_tvalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        kind_b_reg  <= kind_b_next;
    end

    `HCBD_ASSERT_IMP(a_pend_has_first, clk, rst_n, pend_reg, m_tvalid_reg && !m_tlast_reg)
    `HCBD_ASSERT_NXT(a_second_is_marker, clk, rst_n, pend_reg && out_free,
        m_tvalid_reg && m_tlast_reg && (m_tuser_reg != K_DATA))

endmodule

>>> hdl/http_chunked_body_decoder_core.sv
// Chunked transfer body decoder. Raw body bytes enter on the s_ stream, one byte per
// transfer, with s_tlast marking the last byte of a received message. Decoded results
// leave on the m_ stream: m_tuser gives the kind (data byte, end of body, error),
// m_tdata the decoded byte for data results and zero otherwise, and m_tlast marks the
// last result that a given input byte caused. A byte causes zero, one or two results.
// The front stage accepts one byte in every cycle in which the result queue has room
// and updates the size-line, data and trailer state at once. A byte's first result
// is queued, then registered in the back stage. The back stage sends one result per
// cycle while m_tready is high; a byte with two results takes two transfers, and the
// four-entry queue absorbs such bursts and short receiver stalls. When the receiver
// holds m_tready low, the output holds, the queue fills and s_tready falls only once
// all four entries are taken. Reset returns the decoder to the start of a size line
// with an empty queue and no result offered; no clearing pass is needed. After each
// message's last byte the decoder is back at its reset state for the next message.
module http_chunked_body_decoder_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    hcbd_entry_t q_wr_entry;
    hcbd_entry_t q_rd_entry;

    // Front: parses the byte stream and classifies each byte into its results.
    hcbd_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_entry  (q_wr_entry),
        .q_full   (q_full)
    );

    // Queue: decouples parsing from the output handshake.
    hcbd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .rd_entry (q_rd_entry)
    );

    // Back: expands each entry into one or two output transfers.
    hcbd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_rd_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hcbd_pkg::*;

    localparam int SIZE_BITS    = 24;
    localparam int RANDOM_ITEMS = 1900;  // live body bytes in the random part
    localparam int LONG_HOLD    = 120;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 16;    // settling time once nothing is due
    localparam int CYCLE_LIMIT  = 400000;

    // Where the decoder stands within one chunked message.
    typedef enum logic [2:0] {
        PH_SIZE_LINE,
        PH_CHUNK_DATA,
        PH_TRAILER,
        PH_FINISHED,
        PH_FAILED
    } body_phase_t;

    // One decoded result as it should appear on the output stream.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       run_end;
    } decoded_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    http_chunked_body_decoder_core #(
        .SIZE_BITS (SIZE_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decoder state as the testbench expects it to be.
    body_phase_t          body_phase  = PH_SIZE_LINE;
    logic [SIZE_BITS-1:0] size_acc    = '0;
    logic [SIZE_BITS-1:0] chunk_left  = '0;
    bit                   digits_done = 1'b0;
    bit                   have_digit  = 1'b0;

    // Results still owed by the decoder, oldest first.
    decoded_t decoded_due[$];

    // Bytes of the message that is being put together.
    logic [7:0] msg_bytes[$];

    int live_items   = 0;
    int messages     = 0;
    int failures     = 0;
    int data_seen    = 0;
    int end_seen     = 0;
    int err_seen     = 0;
    int input_stalls = 0;
    int cycle_count  = 0;

    // Sender pacing and the handshake with the receiver for a long hold-off.
    bit gaps_on    = 1'b1;
    int burst_left = 0;
    int hold_asks  = 0;

    int hold_seen = 0;
    int hold_cnt  = 0;
    int rx_mode   = 0;
    int rx_left   = 0;
    int rx_tick   = 0;

    function automatic int hex_nibble(logic [7:0] c);
        if (c inside {["0":"9"]})
            return int'(c) - int'("0");
        if (c inside {["a":"f"]})
            return int'(c) - int'("a") + 10;
        if (c inside {["A":"F"]})
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void post_result(kind_t k, logic [7:0] d);
        decoded_t r;
        r.kind    = k;
        r.data    = d;
        r.run_end = 1'b0;
        decoded_due.insert(decoded_due.size(), r);
    endfunction

    function automatic void restart_line();
        size_acc    = '0;
        digits_done = 1'b0;
        have_digit  = 1'b0;
    endfunction

    // Works out what one accepted body byte must produce and advances the
    // expected decoder state.
    function automatic void decode_byte(logic [7:0] c, logic is_last);
        int queued;
        int nib;
        bit too_wide;
        bit takes_digit;
        queued      = decoded_due.size();
        nib         = hex_nibble(c);
        too_wide    = (size_acc[SIZE_BITS-1 -: 4] != 4'd0);
        takes_digit = (c != CH_LF) && (c != CH_CR) && !digits_done && (nib >= 0);
        if (!(body_phase inside {PH_FINISHED, PH_FAILED}))
            live_items++;
        case (body_phase)
            PH_SIZE_LINE:
            begin
                if (c == CH_LF || is_last)
                begin
                    // The line ends here; a digit on the closing byte still counts.
                    if (takes_digit && too_wide)
                    begin
                        post_result(K_ERR, 8'h00);
                        body_phase = PH_FAILED;
                    end
                    else
                    begin
                        if (takes_digit)
                            size_acc = {size_acc[SIZE_BITS-5:0], 4'(nib)};
                        if (size_acc == '0)
                        begin
                            post_result(K_END, 8'h00);
                            body_phase = PH_FINISHED;
                        end
                        else if (is_last)
                        begin
                            post_result(K_ERR, 8'h00);
                            body_phase = PH_FAILED;
                        end
                        else
                        begin
                            chunk_left = size_acc;
                            body_phase = PH_CHUNK_DATA;
                        end
                    end
                end
                else if (c != CH_CR && !digits_done)
                begin
                    if (nib >= 0)
                    begin
                        if (too_wide)
                        begin
                            post_result(K_ERR, 8'h00);
                            body_phase = PH_FAILED;
                        end
                        else
                        begin
                            size_acc   = {size_acc[SIZE_BITS-5:0], 4'(nib)};
                            have_digit = 1'b1;
                        end
                    end
                    else if (!((c inside {CH_SPACE, CH_TAB}) && !have_digit))
                    begin
                        digits_done = 1'b1;
                    end
                end
            end
            PH_CHUNK_DATA:
            begin
                post_result(K_DATA, c);
                chunk_left = chunk_left - 1'b1;
                if (chunk_left == '0)
                begin
                    body_phase = PH_TRAILER;
                    if (is_last)
                        post_result(K_END, 8'h00);
                end
                else if (is_last)
                begin
                    // The message stopped before the chunk was complete.
                    post_result(K_ERR, 8'h00);
                end
            end
            PH_TRAILER:
            begin
                if (is_last)
                begin
                    post_result(K_END, 8'h00);
                end
                else if (c == CH_LF)
                begin
                    restart_line();
                    body_phase = PH_SIZE_LINE;
                end
            end
            default: ;
        endcase
        if (is_last)
        begin
            body_phase = PH_SIZE_LINE;
            chunk_left = '0;
            restart_line();
        end
        if (decoded_due.size() > queued)
            decoded_due[decoded_due.size() - 1].run_end = 1'b1;
    endfunction

    // Observes both streams at every rising edge. A result transfer at this
    // edge always stems from an earlier byte, so it is checked before the
    // byte taken at the same edge is decoded.
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                case (m_tuser)
                    K_DATA:  data_seen++;
                    K_END:   end_seen++;
                    default: err_seen++;
                endcase
                if (decoded_due.size() == 0)
                begin
                    $error("unexpected result: kind %0d, data %02h, last %0b",
                           m_tuser, m_tdata, m_tlast);
                    failures++;
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        failures++;
                    end
                    if (m_tdata !== want.data)
                    begin
                        $error("data_byte: expected %02h, got %02h", want.data, m_tdata);
                        failures++;
                    end
                    if (m_tlast !== want.run_end)
                    begin
                        $error("run_end: expected %0b, got %0b", want.run_end, m_tlast);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (s_tvalid && !s_tready)
                input_stalls++;
        end
    end

    // The receiver switches between stall patterns every so often. A long
    // hold-off requested by a test overrides the pattern.
    always @(posedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_cnt  = LONG_HOLD;
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        rx_tick++;
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 9) != 0);
                default: m_tready <= ((rx_tick % 7) >= 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results still due.",
                     cycle_count, decoded_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void put_byte(logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
        if (nib < 4'd10)
            return 8'("0" + nib);
        if (upper)
            return 8'("A" + nib - 4'd10);
        return 8'("a" + nib - 4'd10);
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_LF);
        return b;
    endfunction

    // Mostly characters that matter on a size line, the rest arbitrary.
    function automatic logic [7:0] noise_byte();
        string glyphs = "0123456789abcdefABCDEF \t\n;g";
        if ($urandom_range(0, 2) == 0)
            return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            return CH_CR;
        return glyphs[$urandom_range(0, glyphs.len() - 1)];
    endfunction

    function automatic void put_size(longint unsigned v);
        int nd;
        nd = 1;
        while (nd < 16 && (v >> (4 * nd)) != 0)
            nd++;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) put_byte("0");
        for (int i = nd - 1; i >= 0; i--)
            put_byte(hex_char(4'(v >> (4 * i)), 1'($urandom_range(0, 1))));
    endfunction

    // A size line with optional leading blanks, an optional extension and an
    // optional carriage return. A zero size is sometimes left out entirely.
    function automatic void put_size_line(longint unsigned v);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                put_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
        if (v != 0 || $urandom_range(0, 9) != 0)
            put_size(v);
        if ($urandom_range(0, 3) == 0)
        begin
            put_byte(";");
            repeat ($urandom_range(1, 6)) put_byte(any_but_lf());
        end
        if ($urandom_range(0, 4) != 0)
            put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    function automatic void build_wellformed();
        int len;
        repeat ($urandom_range(0, 4))
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 70)
                                               : $urandom_range(1, 16);
            put_size_line(len);
            repeat (len) put_byte(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
                0:
                begin
                    put_byte(CH_LF);
                end
                1:
                begin
                    repeat ($urandom_range(1, 3)) put_byte(any_but_lf());
                    put_byte(CH_LF);
                end
                default:
                begin
                    put_byte(CH_CR);
                    put_byte(CH_LF);
                end
            endcase
        end
        put_size_line(0);
        if ($urandom_range(0, 2) != 0)
        begin
            put_byte(CH_CR);
            put_byte(CH_LF);
        end
    endfunction

    // Sizes at or beyond the accumulator width, followed by a few bytes, so
    // that the message ends in an overflow or in a short chunk.
    function automatic void build_big_size();
        longint unsigned v;
        case ($urandom_range(0, 2))
            0:       v = (longint'($urandom_range(1, 255)) << SIZE_BITS) | 24'($urandom);
            1:       v = longint'(24'($urandom) | 24'h100000);
            default: v = (longint'(1) << SIZE_BITS) - 1;
        endcase
        put_size_line(v);
        repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 24)) put_byte(noise_byte());
    endfunction

    // Offers one byte and returns at the edge where it was taken.
    task automatic send_byte(logic [7:0] b, logic is_last);
        int gap;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= 8'($urandom_range(0, 255));
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Sends the assembled message up to and including byte cut, which carries
    // the end-of-message mark. A negative cut sends the whole message.
    task automatic send_message(int cut);
        int stop;
        stop = (cut < 0) ? msg_bytes.size() - 1 : cut;
        for (int i = 0; i <= stop; i++)
            send_byte(msg_bytes[i], i == stop);
        msg_bytes.delete();
        messages++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_due.size() != 0)
            @(posedge clk);
    endtask

    // Data bytes at both ends of the range and a carriage return inside a
    // chunk, then bytes after the end of body, then an empty size line.
    task automatic test_data_extremes();
        put_text("3\n");
        put_byte(8'h00);
        put_byte(CH_CR);
        put_byte(8'hFF);
        put_text("\n0\n");
        put_byte("A");
        send_message(-1);
        put_byte(CH_LF);
        send_message(-1);
        drain_results();
    endtask

    // The seventh significant digit no longer fits; what follows is ignored.
    task automatic test_size_overflow();
        put_text("FFFFFFF");
        put_byte(8'h01);
        send_message(-1);
        drain_results();
    endtask

    task automatic test_final_on_size_line();
        put_text("2");
        send_message(-1);
        put_text("0\n");
        send_message(-1);
        put_text("1\n");
        send_message(-1);
        drain_results();
    endtask

    task automatic test_final_in_data();
        put_text("1\n");
        put_byte(8'h55);
        send_message(-1);
        put_text("2\n");
        put_byte(8'hAA);
        send_message(-1);
        drain_results();
    endtask

    task automatic test_final_in_trailer();
        put_text("1\n");
        put_byte(8'h10);
        put_byte(8'h20);
        send_message(-1);
        drain_results();
    endtask

    // The receiver stops for a long stretch while a 40-byte chunk is offered
    // back to back, so the result queue fills and the input stalls.
    task automatic test_receiver_hold();
        gaps_on = 1'b0;
        hold_asks++;
        put_text("28");
        put_byte(CH_CR);
        put_byte(CH_LF);
        repeat (40) put_byte(8'($urandom_range(0, 255)));
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_text("0");
        put_byte(CH_CR);
        put_byte(CH_LF);
        send_message(-1);
        gaps_on = 1'b1;
        drain_results();
    endtask

    // Mostly well-formed messages with random content, some cut short, plus
    // oversized sizes and noise.
    task automatic test_random_messages();
        int start;
        int sel;
        int cut;
        start = live_items;
        while (live_items - start < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 14)
                build_wellformed();
            else if (sel < 16)
                build_big_size();
            else
                build_noise();
            if (sel < 14 && $urandom_range(0, 4) == 0)
                cut = $urandom_range(0, msg_bytes.size() - 1);
            else
                cut = -1;
            send_message(cut);
            if ($urandom_range(0, 29) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_data_extremes();
        test_size_overflow();
        test_final_on_size_line();
        test_final_in_data();
        test_final_in_trailer();
        test_receiver_hold();
        test_random_messages();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Decoded %0d live body bytes in %0d messages: %0d data, %0d end, %0d error.",
                 live_items, messages, data_seen, end_seen, err_seen);
        $display("The input was held back on %0d cycles; %0d results were left unmatched.",
                 input_stalls, decoded_due.size());
        if (failures == 0 && decoded_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/hcbd_pkg.sv
hdl/hcbd_front.sv
hdl/hcbd_queue.sv
hdl/hcbd_back.sv
hdl/http_chunked_body_decoder_core.sv
tb/sv/testbench.sv
